### rtl/ppe_pkg.sv
// shared types and constants of the particle pool engine
package ppe_pkg;

  // field widths of the item ports
  localparam int POS_W   = 24;
  localparam int LIFE_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int RGBA_W  = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // life is unsigned Q1.15, full life is 1.0
  localparam logic [LIFE_W-1:0] LIFE_FULL   = 16'd32768;
  localparam logic [LIFE_W-1:0] DECAY_RESET = 16'd328;

  // item kinds
  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_DRAW  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // operations of the shared arithmetic unit
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [POS_W-1:0] sum;
    logic             live;
  } alu_res_t;

  // write enables of the particle stores
  typedef struct packed {
    logic posx;
    logic posy;
    logic life;
    logic rest;
  } wr_en_t;

  // registered read data of one slot
  typedef struct packed {
    logic [POS_W-1:0]  posx;
    logic [POS_W-1:0]  posy;
    logic [POS_W-1:0]  velx;
    logic [POS_W-1:0]  vely;
    logic [LIFE_W-1:0] life;
    logic [SIZE_W-1:0] size;
    logic [RGBA_W-1:0] rgba;
  } store_rd_t;

endpackage

### rtl/ppe_alu.sv
// shared adder: position step and life decay with a live flag
module ppe_alu (
  input  ppe_pkg::alu_op_e            op_i,
  input  logic [ppe_pkg::POS_W-1:0]   a_i,
  input  logic [ppe_pkg::POS_W-1:0]   b_i,
  output ppe_pkg::alu_res_t           res_o
);

  logic [ppe_pkg::POS_W:0] b_ext;
  logic [ppe_pkg::POS_W:0] full;

  // one adder, operand b inverted for subtract
  assign b_ext = (op_i == ppe_pkg::ALU_SUB) ? ~{1'b0, b_i} : {1'b0, b_i};
  assign full  = {1'b0, a_i} + b_ext + {{ppe_pkg::POS_W{1'b0}}, (op_i == ppe_pkg::ALU_SUB)};

  // life stays when no borrow and a nonzero difference; top bit set means borrow
  assign res_o.sum  = full[ppe_pkg::POS_W-1:0];
  assign res_o.live = !full[ppe_pkg::POS_W] && (full[ppe_pkg::POS_W-1:0] != '0);

endmodule

### rtl/ppe_store.sv
// particle stores: one write and one registered read per cycle
module ppe_store #(
  parameter int SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr_i,
  input  ppe_pkg::wr_en_t               we_i,
  input  logic [ppe_pkg::POS_W-1:0]     posx_i,
  input  logic [ppe_pkg::POS_W-1:0]     posy_i,
  input  logic [ppe_pkg::POS_W-1:0]     velx_i,
  input  logic [ppe_pkg::POS_W-1:0]     vely_i,
  input  logic [ppe_pkg::LIFE_W-1:0]    life_i,
  input  logic [ppe_pkg::SIZE_W-1:0]    size_i,
  input  logic [ppe_pkg::RGBA_W-1:0]    rgba_i,
  output ppe_pkg::store_rd_t            rd_o
);

  logic [ppe_pkg::POS_W-1:0]  posx_mem [SLOTS];
  logic [ppe_pkg::POS_W-1:0]  posy_mem [SLOTS];
  logic [ppe_pkg::POS_W-1:0]  velx_mem [SLOTS];
  logic [ppe_pkg::POS_W-1:0]  vely_mem [SLOTS];
  logic [ppe_pkg::LIFE_W-1:0] life_mem [SLOTS];
  logic [ppe_pkg::SIZE_W-1:0] size_mem [SLOTS];
  logic [ppe_pkg::RGBA_W-1:0] rgba_mem [SLOTS];
  ppe_pkg::store_rd_t         rd_q;

  // writes
  always_ff @(posedge clk_i) begin
    if (we_i.posx) begin
      posx_mem[wr_addr_i] <= posx_i;
    end
    if (we_i.posy) begin
      posy_mem[wr_addr_i] <= posy_i;
    end
    if (we_i.life) begin
      life_mem[wr_addr_i] <= life_i;
    end
    if (we_i.rest) begin
      velx_mem[wr_addr_i] <= velx_i;
      vely_mem[wr_addr_i] <= vely_i;
      size_mem[wr_addr_i] <= size_i;
      rgba_mem[wr_addr_i] <= rgba_i;
    end
  end

  // registered reads, all stores at one address
  always_ff @(posedge clk_i) begin
    rd_q.posx <= posx_mem[rd_addr_i];
    rd_q.posy <= posy_mem[rd_addr_i];
    rd_q.velx <= velx_mem[rd_addr_i];
    rd_q.vely <= vely_mem[rd_addr_i];
    rd_q.life <= life_mem[rd_addr_i];
    rd_q.size <= size_mem[rd_addr_i];
    rd_q.rgba <= rgba_mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule

### rtl/particle_pool_engine_unit.sv
// particle pool engine top level: sequencer, live flags and result registers
//
// One item is taken when start is high and busy is low; busy stays high
// until the item is finished. Results come out of registers, one per cycle at
// most, each shown for exactly one cycle with done_o high; the receiver must
// take them as they come. A spawn searches the slots for a dead one and then
// writes it; a tick visits every slot, steps position and life of each live
// slot and then gives its result; a draw visits the slots up to the last live
// slot, or gives one blank result without going busy when no slot is live.
// Each result shows in the cycle after the one that forms it. This pace
// follows from the single shared adder, used three times per live slot, and
// from the stores' single registered read port. Decay rate is written through
// the cfg channel, which is always ready;
// write it only while busy is low.
module particle_pool_engine_unit #(
  parameter int SLOTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind_i,
  input  logic signed [ppe_pkg::POS_W-1:0]    spawn_x_i,
  input  logic signed [ppe_pkg::POS_W-1:0]    spawn_y_i,
  input  logic signed [ppe_pkg::POS_W-1:0]    vel_x_i,
  input  logic signed [ppe_pkg::POS_W-1:0]    vel_y_i,
  input  logic [ppe_pkg::SIZE_W-1:0]          size_i,
  input  logic [ppe_pkg::RGBA_W-1:0]          rgba_i,
  output logic                                done_o,
  output logic [ppe_pkg::SLOT_W-1:0]          slot_o,
  output logic signed [ppe_pkg::POS_W-1:0]    out_x_o,
  output logic signed [ppe_pkg::POS_W-1:0]    out_y_o,
  output logic [ppe_pkg::SIZE_W-1:0]          out_size_o,
  output logic [ppe_pkg::RGBA_W-1:0]          out_rgba_o,
  output logic                                alive_flag_o,
  output logic [ppe_pkg::COUNT_W-1:0]         alive_count_o,
  output logic                                last_o,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppe_pkg::LIFE_W-1:0]          cfg_data_i
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_HI  = 4'd1;
  localparam logic [3:0] S_SRCH_LO  = 4'd2;
  localparam logic [3:0] S_SPAWN_WR = 4'd3;
  localparam logic [3:0] S_TICK_CHK = 4'd4;
  localparam logic [3:0] S_TICK_X   = 4'd5;
  localparam logic [3:0] S_TICK_Y   = 4'd6;
  localparam logic [3:0] S_TICK_L   = 4'd7;
  localparam logic [3:0] S_TICK_END = 4'd8;
  localparam logic [3:0] S_DRAW_CHK = 4'd9;
  localparam logic [3:0] S_DRAW_OUT = 4'd10;

  logic [3:0]                  state_q, state_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [IW-1:0]               hint_q, hint_d;
  logic                        found_q, found_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [SLOTS-1:0]            live_q, live_d;
  logic [ppe_pkg::LIFE_W-1:0]  decay_q;

  // latched spawn payload
  logic [ppe_pkg::POS_W-1:0]   sx_q, sy_q, vx_q, vy_q;
  logic [ppe_pkg::SIZE_W-1:0]  size_q;
  logic [ppe_pkg::RGBA_W-1:0]  rgba_q;

  // result registers
  logic                        done_q, done_d;
  logic [ppe_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [ppe_pkg::POS_W-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic [ppe_pkg::SIZE_W-1:0]  osize_q, osize_d;
  logic [ppe_pkg::RGBA_W-1:0]  orgba_q, orgba_d;
  logic                        oalive_q, oalive_d;
  logic [ppe_pkg::COUNT_W-1:0] ocount_q, ocount_d;
  logic                        olast_q, olast_d;

  logic                        accept;
  logic                        spawn_wr;
  logic                        hint_in_range;
  logic [SLOTS-1:0]            above;
  logic                        none_above;
  ppe_pkg::alu_op_e            alu_op;
  logic [ppe_pkg::POS_W-1:0]   alu_a, alu_b;
  ppe_pkg::alu_res_t           alu_res;
  ppe_pkg::wr_en_t             we;
  ppe_pkg::store_rd_t          rd;
  logic [ppe_pkg::POS_W-1:0]   posx_wd, posy_wd;
  logic [ppe_pkg::LIFE_W-1:0]  life_wd;

  assign accept        = start && (state_q == S_IDLE);
  assign busy          = (state_q != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign spawn_wr      = (state_q == S_SPAWN_WR);
  assign hint_in_range = ({1'b0, hint_q} < (IW + 1)'(SLOTS));

  // live slots above the current index, for the draw last marker
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (j > int'(idx_q));
    end
  end
  assign none_above = ~|(live_q & above);

  // shared unit operand selection
  always_comb begin
    alu_op = ppe_pkg::ALU_ADD;
    alu_a  = rd.posx;
    alu_b  = rd.velx;
    case (state_q)
      S_TICK_Y: begin
        alu_a = rd.posy;
        alu_b = rd.vely;
      end
      S_TICK_L: begin
        alu_op = ppe_pkg::ALU_SUB;
        alu_a  = ppe_pkg::POS_W'(rd.life);
        alu_b  = ppe_pkg::POS_W'(decay_q);
      end
      default: begin
        alu_op = ppe_pkg::ALU_ADD;
      end
    endcase
  end

  ppe_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // store write port
  assign we.posx = spawn_wr || (state_q == S_TICK_X);
  assign we.posy = spawn_wr || (state_q == S_TICK_Y);
  assign we.life = spawn_wr || (state_q == S_TICK_L);
  assign we.rest = spawn_wr;
  assign posx_wd = spawn_wr ? sx_q : alu_res.sum;
  assign posy_wd = spawn_wr ? sy_q : alu_res.sum;
  assign life_wd = spawn_wr ? ppe_pkg::LIFE_FULL : alu_res.sum[ppe_pkg::LIFE_W-1:0];

  ppe_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (idx_q),
    .wr_addr_i (idx_q),
    .we_i      (we),
    .posx_i    (posx_wd),
    .posy_i    (posy_wd),
    .velx_i    (vx_q),
    .vely_i    (vy_q),
    .life_i    (life_wd),
    .size_i    (size_q),
    .rgba_i    (rgba_q),
    .rd_o      (rd)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    hint_d   = hint_q;
    found_d  = found_q;
    cnt_d    = cnt_q;
    live_d   = live_q;
    done_d   = 1'b0;
    slot_d   = slot_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    osize_d  = osize_q;
    orgba_d  = orgba_q;
    oalive_d = oalive_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            ppe_pkg::KIND_SPAWN: begin
              if (hint_in_range) begin
                idx_d   = hint_q;
                state_d = S_SRCH_HI;
              end else begin
                idx_d   = '0;
                state_d = S_SRCH_LO;
              end
            end
            ppe_pkg::KIND_TICK: begin
              idx_d   = '0;
              cnt_d   = '0;
              state_d = S_TICK_CHK;
            end
            ppe_pkg::KIND_DRAW: begin
              idx_d = '0;
              if (live_q == '0) begin
                // empty draw gives one blank result
                done_d   = 1'b1;
                slot_d   = '0;
                ox_d     = '0;
                oy_d     = '0;
                osize_d  = '0;
                orgba_d  = '0;
                oalive_d = 1'b0;
                ocount_d = '0;
                olast_d  = 1'b1;
              end else begin
                state_d = S_DRAW_CHK;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // dead slot search from the hint upward
      S_SRCH_HI: begin
        if (!live_q[idx_q]) begin
          found_d = 1'b1;
          state_d = S_SPAWN_WR;
        end else if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = S_SRCH_LO;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // dead slot search from slot zero; a full pool falls back to slot zero
      S_SRCH_LO: begin
        if (!live_q[idx_q]) begin
          found_d = 1'b1;
          state_d = S_SPAWN_WR;
        end else if (idx_q == IDX_LAST) begin
          found_d = 1'b0;
          idx_d   = '0;
          state_d = S_SPAWN_WR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SPAWN_WR: begin
        live_d[idx_q] = 1'b1;
        if (found_q) begin
          hint_d = idx_q;
        end
        done_d   = 1'b1;
        slot_d   = ppe_pkg::SLOT_W'(idx_q);
        ox_d     = '0;
        oy_d     = '0;
        osize_d  = '0;
        orgba_d  = '0;
        oalive_d = 1'b1;
        ocount_d = '0;
        olast_d  = 1'b1;
        state_d  = S_IDLE;
      end
      // live check; the read of this slot is under way
      S_TICK_CHK: begin
        if (live_q[idx_q]) begin
          state_d = S_TICK_X;
        end else if (idx_q == IDX_LAST) begin
          state_d = S_TICK_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TICK_X: begin
        state_d = S_TICK_Y;
      end
      S_TICK_Y: begin
        state_d = S_TICK_L;
      end
      S_TICK_L: begin
        live_d[idx_q] = alu_res.live;
        cnt_d         = cnt_q + CW'(alu_res.live);
        if (idx_q == IDX_LAST) begin
          state_d = S_TICK_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_TICK_CHK;
        end
      end
      S_TICK_END: begin
        done_d   = 1'b1;
        slot_d   = '0;
        ox_d     = '0;
        oy_d     = '0;
        osize_d  = '0;
        orgba_d  = '0;
        oalive_d = 1'b0;
        ocount_d = ppe_pkg::COUNT_W'(cnt_q);
        olast_d  = 1'b1;
        state_d  = S_IDLE;
      end
      S_DRAW_CHK: begin
        if (live_q[idx_q]) begin
          state_d = S_DRAW_OUT;
        end else if (idx_q == IDX_LAST) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAW_OUT: begin
        done_d   = 1'b1;
        slot_d   = ppe_pkg::SLOT_W'(idx_q);
        ox_d     = rd.posx;
        oy_d     = rd.posy;
        osize_d  = rd.size;
        orgba_d  = rd.rgba;
        oalive_d = 1'b1;
        ocount_d = '0;
        olast_d  = none_above;
        if (none_above || (idx_q == IDX_LAST)) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DRAW_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      hint_q  <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
      decay_q <= ppe_pkg::DECAY_RESET;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hint_q  <= hint_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      live_q  <= live_d;
      done_q  <= done_d;
      if (cfg_valid && cfg_ready) begin
        decay_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q   <= spawn_x_i;
      sy_q   <= spawn_y_i;
      vx_q   <= vel_x_i;
      vy_q   <= vel_y_i;
      size_q <= size_i;
      rgba_q <= rgba_i;
    end
    slot_q   <= slot_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    osize_q  <= osize_d;
    orgba_q  <= orgba_d;
    oalive_q <= oalive_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
  end

  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_size_o    = osize_q;
  assign out_rgba_o    = orgba_q;
  assign alive_flag_o  = oalive_q;
  assign alive_count_o = ocount_q;
  assign last_o        = olast_q;

endmodule

### rtl/ppe_checker.sv
// port level checks of the particle pool engine, bound to the top level
module ppe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   kind_i,
  input logic                         done_o,
  input logic                         alive_flag_o,
  input logic [ppe_pkg::COUNT_W-1:0]  alive_count_o,
  input logic                         last_o
);

  logic take;
  assign take = start && !busy;

  // unused kind leaves the block idle
  a_none_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (kind_i == ppe_pkg::KIND_NONE) |=> !busy && !done_o)
    else $error("unused kind started work");

  // a spawn always goes through the slot search
  a_spawn_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (kind_i == ppe_pkg::KIND_SPAWN) |=> busy)
    else $error("spawn did not start the search");

  // a nonzero live count comes only as a single tick result
  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (alive_count_o != '0) |-> last_o && !alive_flag_o)
    else $error("live count on a non-final result");

  // results without a live particle are always final
  a_dead_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !alive_flag_o |-> last_o)
    else $error("empty result not marked last");

endmodule

bind particle_pool_engine_unit ppe_checker u_ppe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .kind_i        (kind_i),
  .done_o        (done_o),
  .alive_flag_o  (alive_flag_o),
  .alive_count_o (alive_count_o),
  .last_o        (last_o)
);
